>>> rtl/sat_pkg.sv
// Shared types, codes and widths for the sorted array table.
package sat_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W = 6;
  localparam int COUNT_OUT_W = 7;
  localparam int DEPTH_DEF = 64;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_REVERSE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]        position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_OUT_W-1:0]    entry_count;
  } rsp_t;

endpackage

>>> rtl/sorted_array_table.sv
// Top level of the sorted array table: stream ports and the result register.
// A read, an error, a full table or a reverse of fewer than two entries walks no entries;
// an insert shifts entries up from the end to its landing place, a delete shifts those
// above the position down, and a reverse swaps pairs from both ends inward. One transaction
// at a time; the next is accepted once the last result is handed on. One two-port RAM.
// Synchronous active-low reset empties the table and clears the handshakes.
module sorted_array_table #(
  parameter int DEPTH = sat_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // value [31:0], position [37:32], zero fill
  input  logic [1:0]  in_tuser,  // action [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // read_value [31:0], entry_count [38:32], zero fill
  output logic [1:0]  out_tuser  // status [1:0]
);

  sat_pkg::cmd_t cmd;
  sat_pkg::rsp_t rsp;
  sat_pkg::rsp_t out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          rsp_valid;
  logic          rsp_ready;

  assign cmd.action = in_tuser;
  assign cmd.value = in_tdata[31:0];
  assign cmd.position = in_tdata[37:32];

  sat_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(in_tvalid),
    .cmd_ready(in_tready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  assign rsp_ready = !out_valid_r || out_tready;

  always_comb begin
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (rsp_valid && rsp_ready) begin
      out_nxt = rsp;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_r.status;
  assign out_tdata = {1'b0, out_r.entry_count, out_r.read_value};

endmodule

>>> rtl/sat_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sat_core.sv
// Sequencer that walks the entry RAM one place per cycle for insert and delete, pair by pair for reverse.
module sat_core #(
  parameter int DEPTH = sat_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  sat_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sat_pkg::rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > sat_pkg::COUNT_OUT_W) ? CW : sat_pkg::COUNT_OUT_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
  localparam logic [XW-1:0] ONE_X = XW'(1);
  localparam logic [XW:0] TWO_W = (XW + 1)'(2);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_INS = 4'd2;
  localparam logic [3:0] S_INS0 = 4'd3;
  localparam logic [3:0] S_DEL = 4'd4;
  localparam logic [3:0] S_RD = 4'd5;
  localparam logic [3:0] S_RVB = 4'd6;
  localparam logic [3:0] S_RVC = 4'd7;
  localparam logic [3:0] S_RVD = 4'd8;
  localparam logic [3:0] S_FIN = 4'd9;

  logic [3:0]                         state_r, state_nxt;
  sat_pkg::cmd_t                      cmd_r, cmd_nxt;
  logic [CW-1:0]                      count_r, count_nxt;
  logic [XW-1:0]                      idx_r, idx_nxt;
  logic [XW-1:0]                      hi_r, hi_nxt;
  logic [sat_pkg::VALUE_W-1:0]        tmp_r, tmp_nxt;
  logic [1:0]                         status_r, status_nxt;
  logic [sat_pkg::VALUE_W-1:0]        rd_r, rd_nxt;

  logic                               ram_we;
  logic [AW-1:0]                      ram_waddr;
  logic [sat_pkg::VALUE_W-1:0]        ram_wdata;
  logic [AW-1:0]                      ram_raddr;
  logic [sat_pkg::VALUE_W-1:0]        ram_rdata;

  logic [XW-1:0]                      cnt_x;
  logic [XW-1:0]                      pos_x;
  logic [XW-1:0]                      idx_m1;
  logic [XW-1:0]                      idx_p1;
  logic [XW-1:0]                      hi_m1;
  logic                               greater;

  sat_ram #(
    .WIDTH(sat_pkg::VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cnt_x = XW'(count_r);
  assign pos_x = XW'(cmd_r.position);
  assign idx_m1 = idx_r - ONE_X;
  assign idx_p1 = idx_r + ONE_X;
  assign hi_m1 = hi_r - ONE_X;
  assign greater = $signed(ram_rdata) > $signed(cmd_r.value);

  assign cmd_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_FIN);
  assign rsp.status = status_r;
  assign rsp.read_value = rd_r;
  assign rsp.entry_count = cnt_x[sat_pkg::COUNT_OUT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    hi_nxt = hi_r;
    tmp_nxt = tmp_r;
    status_nxt = status_r;
    rd_nxt = rd_r;
    ram_we = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = cmd;
          status_nxt = sat_pkg::ST_OK;
          rd_nxt = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        case (cmd_r.action)
          sat_pkg::ACT_INSERT: begin
            if (cnt_x == DEPTH_X) begin
              status_nxt = sat_pkg::ST_FULL;
              state_nxt = S_FIN;
            end else if (count_r == '0) begin
              ram_we = 1'b1;
              ram_waddr = '0;
              ram_wdata = cmd_r.value;
              count_nxt = count_r + CW'(1);
              state_nxt = S_FIN;
            end else begin
              ram_raddr = AW'(cnt_x - ONE_X);
              idx_nxt = cnt_x;
              state_nxt = S_INS;
            end
          end
          sat_pkg::ACT_DELETE, sat_pkg::ACT_READ: begin
            if (count_r == '0) begin
              status_nxt = sat_pkg::ST_EMPTY;
              state_nxt = S_FIN;
            end else if (pos_x >= cnt_x) begin
              status_nxt = sat_pkg::ST_RANGE;
              state_nxt = S_FIN;
            end else if (cmd_r.action == sat_pkg::ACT_READ) begin
              ram_raddr = pos_x[AW-1:0];
              state_nxt = S_RD;
            end else if ((pos_x + ONE_X) < cnt_x) begin
              ram_raddr = AW'(pos_x + ONE_X);
              idx_nxt = pos_x;
              state_nxt = S_DEL;
            end else begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_FIN;
            end
          end
          default: begin
            if (cnt_x < XW'(2)) begin
              state_nxt = S_FIN;
            end else begin
              ram_raddr = '0;
              idx_nxt = '0;
              hi_nxt = cnt_x - ONE_X;
              state_nxt = S_RVB;
            end
          end
        endcase
      end
      S_INS: begin
        ram_we = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        if (greater) begin
          ram_wdata = ram_rdata;
          idx_nxt = idx_m1;
          if (idx_r == ONE_X) begin
            state_nxt = S_INS0;
          end else begin
            ram_raddr = AW'(idx_r - XW'(2));
          end
        end else begin
          ram_wdata = cmd_r.value;
          count_nxt = count_r + CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_INS0: begin
        ram_we = 1'b1;
        ram_waddr = '0;
        ram_wdata = cmd_r.value;
        count_nxt = count_r + CW'(1);
        state_nxt = S_FIN;
      end
      S_DEL: begin
        ram_we = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        if (({1'b0, idx_r} + TWO_W) < {1'b0, cnt_x}) begin
          ram_raddr = AW'(idx_r + XW'(2));
          idx_nxt = idx_p1;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_RD: begin
        rd_nxt = ram_rdata;
        state_nxt = S_FIN;
      end
      S_RVB: begin
        ram_raddr = hi_r[AW-1:0];
        tmp_nxt = ram_rdata;
        state_nxt = S_RVC;
      end
      S_RVC: begin
        ram_we = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        state_nxt = S_RVD;
      end
      S_RVD: begin
        ram_we = 1'b1;
        ram_waddr = hi_r[AW-1:0];
        ram_wdata = tmp_r;
        idx_nxt = idx_p1;
        hi_nxt = hi_m1;
        if (({1'b0, idx_p1} + TWO_W) <= {1'b0, hi_r}) begin
          ram_raddr = idx_p1[AW-1:0];
          state_nxt = S_RVB;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    hi_r <= hi_nxt;
    tmp_r <= tmp_nxt;
    status_r <= status_nxt;
    rd_r <= rd_nxt;
  end

endmodule

>>> test/sat_checker.sv
// Checker for the sorted array table: predicts every result and compares it.
module sat_checker #(
  parameter int DEPTH = sat_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fails,
  output int          owed
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [sat_pkg::VALUE_W-1:0] tbl_entries [DEPTH];
  int                                 tbl_count;
  sat_pkg::rsp_t                      expected_rsp [$];
  int                                 err_count;

  initial begin
    fails = 0;
    owed = 0;
    err_count = 0;
    tbl_count = 0;
  end

  function automatic sat_pkg::rsp_t table_step(input sat_pkg::cmd_t cmd);
    sat_pkg::rsp_t                      rsp;
    int                                 i;
    int                                 lo;
    int                                 hi;
    logic signed [sat_pkg::VALUE_W-1:0] tmp;
    rsp.status = sat_pkg::ST_OK;
    rsp.read_value = '0;
    case (cmd.action)
      sat_pkg::ACT_INSERT: begin
        if (tbl_count >= DEPTH) begin
          rsp.status = sat_pkg::ST_FULL;
        end else begin
          i = tbl_count;
          while (i > 0 && tbl_entries[i-1] > cmd.value) begin
            tbl_entries[i] = tbl_entries[i-1];
            i--;
          end
          tbl_entries[i] = cmd.value;
          tbl_count++;
        end
      end
      sat_pkg::ACT_DELETE: begin
        if (tbl_count == 0) begin
          rsp.status = sat_pkg::ST_EMPTY;
        end else if (int'(cmd.position) >= tbl_count) begin
          rsp.status = sat_pkg::ST_RANGE;
        end else begin
          for (i = int'(cmd.position); i + 1 < tbl_count; i++) begin
            tbl_entries[i] = tbl_entries[i+1];
          end
          tbl_count--;
        end
      end
      sat_pkg::ACT_READ: begin
        if (tbl_count == 0) begin
          rsp.status = sat_pkg::ST_EMPTY;
        end else if (int'(cmd.position) >= tbl_count) begin
          rsp.status = sat_pkg::ST_RANGE;
        end else begin
          rsp.read_value = tbl_entries[cmd.position];
        end
      end
      default: begin
        lo = 0;
        hi = tbl_count - 1;
        while (lo < hi) begin
          tmp = tbl_entries[lo];
          tbl_entries[lo] = tbl_entries[hi];
          tbl_entries[hi] = tmp;
          lo++;
          hi--;
        end
      end
    endcase
    rsp.entry_count = sat_pkg::COUNT_OUT_W'(tbl_count);
    return rsp;
  endfunction

  always @(posedge clk) begin
    sat_pkg::cmd_t cmd;
    sat_pkg::rsp_t got;
    sat_pkg::rsp_t want;
    if (!rst_n) begin
      tbl_count = 0;
      expected_rsp.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        cmd.action = in_tuser;
        cmd.value = in_tdata[31:0];
        cmd.position = in_tdata[37:32];
        expected_rsp.push_back(table_step(cmd));
      end
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.read_value = out_tdata[31:0];
        got.entry_count = out_tdata[38:32];
        if (expected_rsp.size() == 0) begin
          $error("unexpected result: status %0d, read_value %0d, entry_count %0d",
                 got.status, got.read_value, got.entry_count);
          err_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_count++;
          end
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
            err_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   got.entry_count);
            err_count++;
          end
        end
      end
    end
    fails <= err_count;
    owed <= expected_rsp.size();
  end

endmodule

>>> test/sorted_array_table_tb.sv
// Testbench top for the sorted array table: clock, reset, stimulus and verdict.
module sorted_array_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH = sat_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_ITEMS = 650;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = sat_pkg::ACT_INSERT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  int          fails;
  int          owed;

  int cycles = 0;
  int held = 0;
  int issued = 0;
  int stall_left = 0;
  int phase = 0;
  bit no_idle = 1'b0;

  sorted_array_table #(
    .DEPTH(TBL_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  sat_checker #(
    .DEPTH(TBL_DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fails      (fails),
    .owed       (owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end else if (r < 4) begin
      return $signed(32'($urandom_range(0, 20))) - 32'sd10;
    end
    return $signed(32'($urandom));
  endfunction

  function automatic logic [5:0] pick_pos();
    if (held > 0 && $urandom_range(0, 3) != 0) begin
      return 6'($urandom_range(0, held - 1));
    end
    return 6'($urandom_range(0, 63));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_tready <= 1'b1;
    end
  end

  task automatic push_cmd(input logic [1:0] act, input logic signed [31:0] val,
                          input logic [5:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {2'b00, pos, val};
    do @(posedge clk); while (!in_tready);
    issued++;
    case (act)
      sat_pkg::ACT_INSERT: if (held < TBL_DEPTH) held++;
      sat_pkg::ACT_DELETE: if (held > 0 && int'(pos) < held) held--;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_cmd(sat_pkg::ACT_READ, 32'sd0, 6'd0);
    push_cmd(sat_pkg::ACT_DELETE, 32'sd0, 6'd5);
    push_cmd(sat_pkg::ACT_REVERSE, 32'sd0, 6'd0);
    push_cmd(sat_pkg::ACT_INSERT, 32'sd0, 6'd0);
    push_cmd(sat_pkg::ACT_REVERSE, 32'sd0, 6'd0);
    push_cmd(sat_pkg::ACT_READ, 32'sd0, 6'd0);
    push_cmd(sat_pkg::ACT_READ, 32'sd0, 6'd63);
    push_cmd(sat_pkg::ACT_DELETE, 32'sd0, 6'd1);
    push_cmd(sat_pkg::ACT_INSERT, 32'sh7fff_ffff, 6'd63);
    push_cmd(sat_pkg::ACT_INSERT, 32'sh8000_0000, 6'd0);
    push_cmd(sat_pkg::ACT_INSERT, -32'sd1, 6'd0);
    push_cmd(sat_pkg::ACT_INSERT, 32'sd5, 6'd0);
    push_cmd(sat_pkg::ACT_INSERT, 32'sd5, 6'd0);
    push_cmd(sat_pkg::ACT_INSERT, 32'sd0, 6'd0);
    push_cmd(sat_pkg::ACT_READ, 32'sd0, 6'd0);
    push_cmd(sat_pkg::ACT_READ, 32'sd0, 6'd6);
    push_cmd(sat_pkg::ACT_REVERSE, 32'sd0, 6'd0);
    push_cmd(sat_pkg::ACT_READ, 32'sd0, 6'd0);
    push_cmd(sat_pkg::ACT_READ, 32'sd0, 6'd7);
    push_cmd(sat_pkg::ACT_DELETE, 32'sd0, 6'd0);
    push_cmd(sat_pkg::ACT_DELETE, 32'sd0, 6'd5);
    push_cmd(sat_pkg::ACT_DELETE, 32'sd0, 6'd2);
    push_cmd(sat_pkg::ACT_INSERT, 32'sd3, 6'd0);
    push_cmd(sat_pkg::ACT_READ, 32'sd0, 6'd1);
    push_cmd(sat_pkg::ACT_REVERSE, 32'sd0, 6'd0);

    while (issued < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ((phase < 2) ? phase : $urandom_range(0, 3))
        0: begin
          while (held < TBL_DEPTH) begin
            if ($urandom_range(0, 9) < 8) begin
              push_cmd(sat_pkg::ACT_INSERT, pick_value(), 6'($urandom_range(0, 63)));
            end else begin
              push_cmd(2'($urandom_range(1, 3)), pick_value(), pick_pos());
            end
          end
          repeat (3) begin
            push_cmd(sat_pkg::ACT_INSERT, pick_value(), 6'($urandom_range(0, 63)));
          end
          push_cmd(sat_pkg::ACT_READ, pick_value(), 6'd63);
          push_cmd(sat_pkg::ACT_REVERSE, pick_value(), pick_pos());
          push_cmd(sat_pkg::ACT_READ, pick_value(), pick_pos());
        end
        1: begin
          while (held > 0) begin
            if ($urandom_range(0, 9) < 8) begin
              push_cmd(sat_pkg::ACT_DELETE, pick_value(), pick_pos());
            end else begin
              push_cmd(2'($urandom_range(0, 3)), pick_value(), pick_pos());
            end
          end
          push_cmd(sat_pkg::ACT_DELETE, pick_value(), 6'($urandom_range(0, 63)));
          push_cmd(sat_pkg::ACT_READ, pick_value(), 6'($urandom_range(0, 63)));
        end
        default: begin
          repeat ($urandom_range(20, 60)) begin
            push_cmd(2'($urandom_range(0, 3)), pick_value(), pick_pos());
          end
        end
      endcase
      if (phase == 0) begin
        wait_drained();
      end
      phase++;
    end

    wait_drained();
    repeat (150) @(posedge clk);
    if (fails == 0 && owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
